[design/gha_pkg.sv]
// gha_pkg: shared types and constants of the generational handle allocator
// depends on nothing; imported by every module of the block
`default_nettype none

package gha_pkg;

  // sizes fixed by the field widths of the handle
  localparam int unsigned SLOTS = 1024;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned GEN_W = 16;
  localparam int unsigned CTX_W = 8;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned CMD_W = 2;

  // command codes on the input
  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

  // first generation of a slot, also the value after wrap
  localparam logic [GEN_W-1:0] FIRST_GEN = GEN_W'(1);

  // operation class decided by the front end
  typedef enum logic [1:0] {
    OP_CREATE,
    OP_DESTROY,
    OP_CHECK,
    OP_NONE
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_NULL    = 2'd2,
    STS_UNALLOC = 2'd3
  } status_e;

  // back end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  // input beat
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [CTX_W-1:0] context_tag;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] generation;
  } gha_in_t;

  // result beat
  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic [GEN_W-1:0] out_generation;
    logic [CTX_W-1:0] out_context;
    logic             is_valid;
    logic [CNT_W-1:0] live_count;
    status_e          status;
  } gha_out_t;

  // classified command passed from front to back
  typedef struct packed {
    op_e              op;
    logic             null_gen;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    logic [CTX_W-1:0] ctx;
  } gha_cmd_t;

endpackage

`default_nettype wire

[design/gha_front.sv]
// gha_front: accepts input beats, classifies them and holds them in a
// two-entry command queue; depends on gha_pkg
`default_nettype none

module gha_front import gha_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire gha_in_t  in_item_i,
  output logic          cmd_valid_o,
  output gha_cmd_t      cmd_o,
  input  wire logic     cmd_pop_i
);

  localparam logic [1:0] QDEPTH = 2'd2;

  gha_cmd_t   q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  gha_cmd_t   cls;

  // classify the incoming command
  always_comb begin
    cls.idx      = in_item_i.slot_index;
    cls.gen      = in_item_i.generation;
    cls.ctx      = in_item_i.context_tag;
    cls.null_gen = (in_item_i.generation == '0);
    unique case (in_item_i.command)
      CMD_CREATE:  cls.op = OP_CREATE;
      CMD_DESTROY: cls.op = OP_DESTROY;
      CMD_CHECK:   cls.op = OP_CHECK;
      default:     cls.op = OP_NONE;
    endcase
  end

  // queue handshake
  assign full        = (cnt_q == QDEPTH);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

[design/gha_back.sv]
// gha_back: executes classified commands against the generation memory,
// the free-slot stack and the counters; depends on gha_pkg
`default_nettype none

module gha_back import gha_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  input  wire gha_cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  wire logic     res_full_i,
  output logic          res_push_o,
  output gha_out_t      res_o
);

  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

  // memories: generation per slot, stack of freed slots
  logic [GEN_W-1:0] gen_mem [SLOTS];
  logic [IDX_W-1:0] stk_mem [SLOTS];

  bk_state_e        state_q, state_d;
  gha_cmd_t         item_q;
  logic [CNT_W-1:0] hwm_q, hwm_d;
  logic [CNT_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0] live_q, live_d;
  logic [IDX_W-1:0] top_q, top_d;
  logic [GEN_W-1:0] gen_rd_q;
  logic [IDX_W-1:0] stk_rd_q;

  logic             start;
  logic [IDX_W-1:0] gen_raddr;
  logic [CNT_W-1:0] depth_m2;
  logic             gen_we, stk_we;
  logic [IDX_W-1:0] gen_waddr;
  logic [GEN_W-1:0] gen_wdata;
  logic [IDX_W-1:0] stk_waddr;
  logic             in_hwm;
  logic [GEN_W-1:0] gen_inc;
  logic [GEN_W-1:0] gen_next;

  // issue side: start a command and set up memory reads
  assign start     = (state_q == BK_IDLE) && cmd_valid_i && !res_full_i;
  assign cmd_pop_o = start;
  assign gen_raddr = (cmd_i.op == OP_CREATE) ? top_q : cmd_i.idx;
  assign depth_m2  = depth_q - CNT_W'(2);

  // execute side helpers
  assign in_hwm   = ({1'b0, item_q.idx} < hwm_q);
  assign gen_inc  = gen_rd_q + GEN_W'(1);
  assign gen_next = (gen_inc == '0) ? FIRST_GEN : gen_inc;

  // sequencer and command execution
  always_comb begin
    state_d    = state_q;
    hwm_d      = hwm_q;
    depth_d    = depth_q;
    live_d     = live_q;
    top_d      = top_q;
    gen_we     = 1'b0;
    gen_waddr  = item_q.idx;
    gen_wdata  = gen_next;
    stk_we     = 1'b0;
    stk_waddr  = depth_q[IDX_W-1:0];
    res_push_o = 1'b0;

    res_o.out_index      = item_q.idx;
    res_o.out_generation = '0;
    res_o.out_context    = item_q.ctx;
    res_o.is_valid       = 1'b0;
    res_o.status         = STS_OK;

    unique case (state_q)
      BK_IDLE: begin
        if (start) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_d    = BK_IDLE;
        res_push_o = 1'b1;
        case (item_q.op)
          OP_CREATE: begin
            if (depth_q != '0) begin
              // reuse the most recently freed slot
              res_o.out_index      = top_q;
              res_o.out_generation = gen_rd_q;
              res_o.is_valid       = 1'b1;
              depth_d              = depth_q - CNT_W'(1);
              top_d                = stk_rd_q;
              if (live_q < SLOTS_C) begin
                live_d = live_q + CNT_W'(1);
              end
            end else if (hwm_q != SLOTS_C) begin
              // fresh slot at first generation
              res_o.out_index      = hwm_q[IDX_W-1:0];
              res_o.out_generation = FIRST_GEN;
              res_o.is_valid       = 1'b1;
              gen_we               = 1'b1;
              gen_waddr            = hwm_q[IDX_W-1:0];
              gen_wdata            = FIRST_GEN;
              hwm_d                = hwm_q + CNT_W'(1);
              if (live_q < SLOTS_C) begin
                live_d = live_q + CNT_W'(1);
              end
            end else begin
              res_o.out_index = '0;
              res_o.status    = STS_NO_FREE;
            end
          end
          OP_DESTROY: begin
            if (item_q.null_gen) begin
              res_o.out_generation = in_hwm ? gen_rd_q : '0;
              res_o.status         = STS_NULL;
            end else if (!in_hwm) begin
              res_o.status = STS_UNALLOC;
            end else if (gen_rd_q != item_q.gen) begin
              // stale handle leaves everything as it is
              res_o.out_generation = gen_rd_q;
            end else begin
              res_o.out_generation = gen_next;
              res_o.is_valid       = 1'b1;
              gen_we               = 1'b1;
              if (depth_q < SLOTS_C) begin
                stk_we  = 1'b1;
                depth_d = depth_q + CNT_W'(1);
                top_d   = item_q.idx;
              end
              if (live_q != '0) begin
                live_d = live_q - CNT_W'(1);
              end
            end
          end
          OP_CHECK: begin
            if (!in_hwm) begin
              res_o.status = STS_UNALLOC;
            end else begin
              res_o.out_generation = gen_rd_q;
              res_o.is_valid       = (gen_rd_q == item_q.gen);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    res_o.live_count = live_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      hwm_q   <= '0;
      depth_q <= '0;
      live_q  <= '0;
    end else begin
      state_q <= state_d;
      hwm_q   <= hwm_d;
      depth_q <= depth_d;
      live_q  <= live_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (start) begin
      item_q <= cmd_i;
    end
  end

  // generation memory, one read or one write per cycle
  always_ff @(posedge clk_i) begin
    if (start) begin
      gen_rd_q <= gen_mem[gen_raddr];
    end
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
  end

  // free-slot stack memory, the entry below the cached top is prefetched
  always_ff @(posedge clk_i) begin
    if (start) begin
      stk_rd_q <= stk_mem[depth_m2[IDX_W-1:0]];
    end
    if (stk_we) begin
      stk_mem[stk_waddr] <= item_q.idx;
    end
  end

  // each started command yields exactly one result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (res_push_o && state_q == BK_EXEC))
    else $error("started command did not produce a result");

  // a result is only written into a queue with room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  // counters stay within the slot range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hwm_q <= SLOTS_C) && (depth_q <= SLOTS_C) && (live_q <= SLOTS_C))
    else $error("allocator counter out of range");

  // the high-water mark only grows, by one per fresh create
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hwm_q != $past(hwm_q)) |-> (hwm_q == $past(hwm_q) + CNT_W'(1)))
    else $error("high-water mark moved by other than one");

endmodule

`default_nettype wire

[design/gha_resq.sv]
// gha_resq: two-entry result queue between the back end and the output
// ports; depends on gha_pkg
`default_nettype none

module gha_resq import gha_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire gha_out_t res_i,
  output logic          full_o,
  output logic          empty,
  input  wire logic     pop,
  output gha_out_t      out_item_o
);

  localparam logic [1:0] QDEPTH = 2'd2;

  gha_out_t   q_mem [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  // queue handshake
  assign full_o     = (cnt_q == QDEPTH);
  assign empty      = (cnt_q == 2'd0);
  assign out_item_o = q_mem[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop && !empty;

  // fill count update
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

[design/generational_handle_allocator_core.sv]
// a command waits in the front queue; the back end starts it and reads the
// generation and stack memories, then in BK_EXEC writes them and pushes the result
// into the result queue; it starts no new command until it is back in BK_IDLE
// reset: queues, sequencer and counters clear at once; the memories are not
// cleared and their contents are used only below the high-water mark or the stack depth
// top level: front end, back end and result queue; depends on gha_pkg
`default_nettype none

module generational_handle_allocator_core import gha_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push,
  output logic         full,
  input  wire gha_in_t in_item_i,
  output logic         empty,
  input  wire logic    pop,
  output gha_out_t     out_item_o
);

  logic     cmd_valid;
  gha_cmd_t cmd;
  logic     cmd_pop;
  logic     res_push;
  logic     res_full;
  gha_out_t res;

  // accept and classify
  gha_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // execute against memories and counters
  gha_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // hold results until popped
  gha_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_push),
    .res_i      (res),
    .full_o     (res_full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

[dv/gha_ledger_pkg.sv]
`timescale 1ns / 1ps
// gha_ledger_pkg: mirror of the handle allocator state and the store of awaited results
// depends on gha_pkg for beat types, command codes and sizes
package gha_ledger_pkg;
  import gha_pkg::*;

  // command code that the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  class handle_ledger;
    // mirrored allocator state
    logic [GEN_W-1:0] gen_table [SLOTS];
    logic [IDX_W-1:0] free_slots [SLOTS];
    int unsigned high_water = 0;
    int unsigned free_depth = 0;
    int unsigned live_handles = 0;

    // results predicted but not yet popped
    gha_out_t awaited_results [$];

    // tallies
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned full_hits = 0;
    int unsigned wraps = 0;
    int unsigned cmd_seen [4] = '{0, 0, 0, 0};

    // apply one accepted command to the mirror and queue its result
    function gha_out_t log_command(gha_in_t beat);
      gha_out_t res;
      logic [GEN_W-1:0] stored;
      logic [GEN_W-1:0] next_gen;
      int unsigned slot;
      res.out_index      = beat.slot_index;
      res.out_generation = '0;
      res.out_context    = beat.context_tag;
      res.is_valid       = 1'b0;
      res.status         = STS_OK;
      cmd_seen[beat.command]++;
      case (beat.command)
        CMD_CREATE: begin
          // lifo reuse first, then a fresh slot, else the allocator is full
          if (free_depth > 0) begin
            free_depth--;
            slot = free_slots[free_depth];
          end else if (high_water < SLOTS) begin
            slot = high_water;
            gen_table[slot] = FIRST_GEN;
            high_water++;
          end else begin
            slot = SLOTS;
          end
          if (slot == SLOTS) begin
            res.out_index = '0;
            res.status    = STS_NO_FREE;
            full_hits++;
          end else begin
            if (live_handles < SLOTS) live_handles++;
            res.out_index      = IDX_W'(slot);
            res.out_generation = gen_table[slot];
            res.is_valid       = 1'b1;
          end
        end
        CMD_DESTROY: begin
          // null handle is tested before the index
          if (beat.generation == '0) begin
            res.status = STS_NULL;
            if (beat.slot_index < high_water) res.out_generation = gen_table[beat.slot_index];
          end else if (beat.slot_index >= high_water) begin
            res.status = STS_UNALLOC;
          end else begin
            stored = gen_table[beat.slot_index];
            if (stored != beat.generation) begin
              // stale handle, nothing changes
              res.out_generation = stored;
            end else begin
              next_gen = stored + 1'b1;
              if (next_gen == '0) begin
                next_gen = FIRST_GEN;
                wraps++;
              end
              gen_table[beat.slot_index] = next_gen;
              if (free_depth < SLOTS) begin
                free_slots[free_depth] = beat.slot_index;
                free_depth++;
              end
              if (live_handles > 0) live_handles--;
              res.out_generation = next_gen;
              res.is_valid       = 1'b1;
            end
          end
        end
        CMD_CHECK: begin
          if (beat.slot_index >= high_water) begin
            res.status = STS_UNALLOC;
          end else begin
            stored             = gen_table[beat.slot_index];
            res.out_generation = stored;
            res.is_valid       = (stored == beat.generation);
          end
        end
        default: ;
      endcase
      res.live_count = CNT_W'(live_handles);
      awaited_results = {awaited_results, res};
      return res;
    endfunction

    // one line per mismatch
    task report(string what, int unsigned got_v, int unsigned exp_v);
      errors++;
      $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               results_seen, what, got_v, exp_v);
    endtask

    // compare a popped result with the oldest awaited one
    task match_result(gha_out_t got);
      gha_out_t exp;
      results_seen++;
      if (awaited_results.size() == 0) begin
        report("result with nothing awaited, out_index", got.out_index, 0);
      end else begin
        exp = awaited_results.pop_front();
        if (got.out_index !== exp.out_index)
          report("out_index", got.out_index, exp.out_index);
        if (got.out_generation !== exp.out_generation)
          report("out_generation", got.out_generation, exp.out_generation);
        if (got.out_context !== exp.out_context)
          report("out_context", got.out_context, exp.out_context);
        if (got.is_valid !== exp.is_valid)
          report("is_valid", got.is_valid, exp.is_valid);
        if (got.live_count !== exp.live_count)
          report("live_count", got.live_count, exp.live_count);
        if (got.status !== exp.status)
          report("status", int'(got.status), int'(exp.status));
      end
    endtask
  endclass

endpackage

[dv/tb.sv]
`timescale 1ns / 1ps
// tb: directed and random run of generational_handle_allocator_core against a mirror
// depends on gha_pkg, gha_ledger_pkg and the design sources
module tb;
  import gha_pkg::*;
  import gha_ledger_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_GAP      = 17;
  localparam int unsigned MIXED_BEATS  = 40;
  localparam int unsigned DRAIN_BEATS  = 40;
  localparam int unsigned TAIL_BEATS   = 30;
  localparam int unsigned REUSE_ROUNDS = 10;
  localparam int unsigned END_CYCLES   = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  gha_in_t  in_item_i = '0;
  logic     full;
  logic     empty;
  gha_out_t out_item_o;

  handle_ledger     ledger;
  logic [IDX_W-1:0] live_slots [$];
  int unsigned      tx_max_gap = MAX_GAP;
  int unsigned      rx_max_gap = MAX_GAP;
  bit               hold_rx = 1'b0;
  int unsigned      idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  generational_handle_allocator_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // keep the list of live slots in step with the mirror
  function automatic void track_handle(gha_in_t beat, gha_out_t res);
    int pos;
    pos = -1;
    if (beat.command == CMD_CREATE && res.is_valid) begin
      live_slots = {live_slots, res.out_index};
    end else if (beat.command == CMD_DESTROY && res.is_valid) begin
      for (int i = 0; i < live_slots.size(); i++)
        if (pos < 0 && live_slots[i] == res.out_index) pos = i;
      if (pos >= 0) live_slots.delete(pos);
    end
  endfunction

  // offer one input beat after a random gap and wait for it to be taken
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [CTX_W-1:0] ctx,
                           logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
    gha_in_t     beat;
    gha_out_t    res;
    int unsigned gap;
    beat.command     = cmd;
    beat.context_tag = ctx;
    beat.slot_index  = idx;
    beat.generation  = gen;
    gap = $urandom_range(tx_max_gap, 0);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= beat;
    do @(posedge clk_i); while (full);
    res = ledger.log_command(beat);
    track_handle(beat, res);
  endtask

  task automatic send_create();
    send_beat(CMD_CREATE, CTX_W'($urandom), IDX_W'($urandom), GEN_W'($urandom));
  endtask

  // destroy a live handle, sometimes with a stale generation
  task automatic send_destroy_live();
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    idx = live_slots[$urandom_range(live_slots.size() - 1, 0)];
    gen = ledger.gen_table[idx];
    if ($urandom_range(9, 0) == 0) gen = gen - 1'b1;
    send_beat(CMD_DESTROY, CTX_W'($urandom), idx, gen);
  endtask

  // mixed traffic: mostly well-formed handles, some noise
  task automatic send_mixed();
    int unsigned      roll;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    logic [CMD_W-1:0] cmd;
    roll = $urandom_range(99, 0);
    if (roll < 35) begin
      send_create();
    end else if (roll < 65 && live_slots.size() > 0) begin
      send_destroy_live();
    end else if (roll < 85 && ledger.high_water > 0) begin
      idx = IDX_W'($urandom_range(ledger.high_water - 1, 0));
      gen = ledger.gen_table[idx];
      roll = $urandom_range(9, 0);
      if (roll < 2) gen = gen + 1'b1;
      else if (roll < 4) gen = GEN_W'($urandom);
      send_beat(CMD_CHECK, CTX_W'($urandom), idx, gen);
    end else begin
      cmd = CMD_W'($urandom_range(3, 0));
      gen = ($urandom_range(9, 0) == 0) ? '0 : GEN_W'($urandom);
      send_beat(cmd, CTX_W'($urandom), IDX_W'($urandom), gen);
    end
  endtask

  // idle settings for a stretch of traffic, sometimes with no idling
  task automatic pick_idle_mode();
    tx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
    rx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : MAX_GAP;
  endtask

  // sender stops until every awaited result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    while (ledger.awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni);
    forever begin
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      gap = $urandom_range(rx_max_gap, 0);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      ledger.match_result(out_item_o);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // main sequence
  initial begin
    int unsigned      extra_full;
    logic [IDX_W-1:0] reuse_slot;
    ledger = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty allocator, field extremes, every command and corner case
    send_beat(CMD_CHECK,   8'h00, 10'd0,    16'h0000);
    send_beat(CMD_DESTROY, 8'hff, 10'd1023, 16'hffff);
    send_beat(CMD_DESTROY, 8'h5a, 10'd5,    16'h0000);
    send_beat(CMD_UNUSED,  8'hff, 10'd1023, 16'hffff);
    send_beat(CMD_CREATE,  8'h00, 10'd0,    16'h0000);
    send_beat(CMD_CREATE,  8'hff, 10'd1023, 16'hffff);
    send_beat(CMD_CREATE,  8'ha5, 10'd512,  16'h8000);
    send_beat(CMD_CHECK,   8'h01, 10'd0,    16'h0001);
    send_beat(CMD_CHECK,   8'h80, 10'd1,    16'h0000);
    send_beat(CMD_CHECK,   8'h7f, 10'd2,    16'hffff);
    send_beat(CMD_DESTROY, 8'h11, 10'd1,    16'h0000);
    send_beat(CMD_DESTROY, 8'h22, 10'd1,    16'h0002);
    send_beat(CMD_DESTROY, 8'h33, 10'd1,    16'h0001);
    send_beat(CMD_DESTROY, 8'h44, 10'd1,    16'h0001);
    send_beat(CMD_CHECK,   8'h55, 10'd1,    16'h0001);
    send_beat(CMD_DESTROY, 8'h66, 10'd0,    16'h0001);
    send_beat(CMD_CREATE,  8'h77, 10'd0,    16'h0000);
    send_beat(CMD_CREATE,  8'h88, 10'd0,    16'h0000);
    send_beat(CMD_CREATE,  8'h99, 10'd0,    16'h0000);
    send_beat(CMD_CHECK,   8'haa, 10'd3,    16'h0001);
    send_beat(CMD_DESTROY, 8'hbb, 10'd4,    16'h0001);
    send_beat(CMD_CHECK,   8'hcc, 10'd1023, 16'h0001);
    send_beat(CMD_UNUSED,  8'h00, 10'd0,    16'h0000);

    // mixed random traffic with changing idle patterns
    for (int n = 0; n < MIXED_BEATS; n++) begin
      if (n % 20 == 0) pick_idle_mode();
      send_mixed();
    end

    // fill to capacity while the result side holds off, then hit the full case
    tx_max_gap = 0;
    rx_max_gap = MAX_GAP;
    hold_rx = 1'b1;
    extra_full = 0;
    while (extra_full < 12) begin
      if (ledger.high_water == SLOTS && ledger.free_depth == 0) extra_full++;
      if ($urandom_range(9, 0) != 0) send_create();
      else send_mixed();
      if (extra_full == 1) tx_max_gap = MAX_GAP;
    end

    // destroy-heavy traffic frees slots for lifo reuse
    for (int n = 0; n < DRAIN_BEATS; n++) begin
      if (n % 20 == 0) pick_idle_mode();
      if ($urandom_range(9, 0) < 7 && live_slots.size() > 0) send_destroy_live();
      else send_mixed();
    end
    wait_drained();

    // cycle one slot through several generations at full rate
    tx_max_gap = 0;
    rx_max_gap = 0;
    if (live_slots.size() == 0) send_create();
    reuse_slot = live_slots[$];
    repeat (REUSE_ROUNDS) begin
      send_beat(CMD_DESTROY, CTX_W'($urandom), reuse_slot, ledger.gen_table[reuse_slot]);
      send_create();
    end
    send_beat(CMD_CHECK, CTX_W'($urandom), reuse_slot, ledger.gen_table[reuse_slot]);

    // closing stretch with full idling
    tx_max_gap = MAX_GAP;
    rx_max_gap = MAX_GAP;
    for (int n = 0; n < TAIL_BEATS; n++) send_mixed();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("run covered %0d results: %0d create, %0d destroy, %0d check, %0d unused code",
             ledger.results_seen, ledger.cmd_seen[CMD_CREATE], ledger.cmd_seen[CMD_DESTROY],
             ledger.cmd_seen[CMD_CHECK], ledger.cmd_seen[CMD_UNUSED]);
    $display("allocator full hit %0d times, generation wrapped %0d times, %0d mismatches",
             ledger.full_hits, ledger.wraps, ledger.errors);
    if (ledger.errors == 0 && ledger.awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
